### hdl/keyed_fixed_window_rate_limiter_macros.svh
// assertion macros for the rate limiter
`ifndef KEYED_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`define KEYED_FIXED_WINDOW_RATE_LIMITER_MACROS_SVH
`ifndef SYNTH
`define KFW_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define KFW_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define KFW_ASSERT_IMPL(label, clk, rst_n, a, c)
`define KFW_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### hdl/kfwrl_pkg.sv
// ----------------------------------------------------------------------------
// kfwrl_pkg
// shared types and codes of the keyed fixed-window rate limiter
// ----------------------------------------------------------------------------
`default_nettype none
package kfwrl_pkg;
  localparam logic [2:0] OP_QUERY   = 3'd0;
  localparam logic [2:0] OP_RECORD  = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_CLEANUP = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;

  localparam logic [1:0] REG_LIMIT  = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_IDLE   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WAIT, ST_FINISH, ST_OUT
  } state_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  attempt_limit;
    logic [15:0] window_length;
    logic [15:0] idle_age_limit;
  } cfg_t;
endpackage
`default_nettype wire

### hdl/keyed_fixed_window_rate_limiter.sv
// sequence: query, record, clear and cleanup raise out_tvalid after the states scan,
// wait, finish and out; tick and unknown opcodes go straight to out
// throughput: one word at a time, the next taken the cycle after the result word
// is accepted; each lookup or sweep reads one record per cycle
// reset (synchronous, active low) clears valid bits and seconds counter and loads config defaults
`default_nettype none
`include "keyed_fixed_window_rate_limiter_macros.svh"
module keyed_fixed_window_rate_limiter #(
  parameter int TABLE_ENTRIES = 64,
  parameter int KEY_BITS      = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[2:0], key[34:3], zero fill to 40 bits
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // allowed[0], remaining[8:1], removed_count[15:9], status[16], zero fill
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = AW + 1;
  localparam int KB = (KEY_BITS < 32) ? KEY_BITS : 32;
  // record: key, first time, last time, count
  localparam int RW = KB + 32 + 32 + 8;

  kfwrl_pkg::cfg_t cfg;

  kfwrl_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg_o(cfg)
  );

  kfwrl_pkg::state_t state_r, state_nxt;
  logic [2:0]        op_r;
  logic [KB-1:0]     key_r;
  logic [31:0]       now_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [CW-1:0]     cnt_r;     // address issued
  logic [AW-1:0]     raddr_r;   // address of data now on rd_data
  logic              rvld_r;    // rd_data belongs to the scan
  logic              hit_r;
  logic [AW-1:0]     hit_idx_r;
  logic [RW-1:0]     hit_rec_r;
  logic              free_r;
  logic [AW-1:0]     free_idx_r;
  logic [6:0]        removed_r;
  logic [23:0]       out_r;
  logic              out_vld_r;

  logic [RW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;

  kfwrl_table #(.ENTRIES(TABLE_ENTRIES), .WIDTH(RW)) u_table (
    .clk, .rd_addr(cnt_r[AW-1:0]), .rd_data, .wr_en, .wr_addr, .wr_data
  );

  // record fields of the word now read and of the hit record
  logic [KB-1:0] rd_key;
  logic [31:0]   rd_last;
  logic [31:0]   h_first;
  logic [7:0]    h_count;
  logic          expired;
  assign rd_key  = rd_data[RW-1 -: KB];
  assign rd_last = rd_data[39:8];
  assign h_first = hit_rec_r[71:40];
  assign h_count = hit_rec_r[7:0];
  assign expired = (now_r - h_first) >= {16'd0, cfg.window_length};

  logic stale;
  assign stale = (now_r - rd_last) > {16'd0, cfg.idle_age_limit};

  assign in_tready = (state_r == kfwrl_pkg::ST_IDLE) && !out_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;

  logic accept;
  assign accept = in_tvalid && in_tready;
  logic scan_op;
  assign scan_op = (in_tdata[2:0] == kfwrl_pkg::OP_QUERY)  ||
                   (in_tdata[2:0] == kfwrl_pkg::OP_RECORD) ||
                   (in_tdata[2:0] == kfwrl_pkg::OP_CLEAR)  ||
                   (in_tdata[2:0] == kfwrl_pkg::OP_CLEANUP);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kfwrl_pkg::ST_IDLE:
        if (accept) state_nxt = scan_op ? kfwrl_pkg::ST_SCAN : kfwrl_pkg::ST_OUT;
      kfwrl_pkg::ST_SCAN:
        if (cnt_r == CW'(TABLE_ENTRIES - 1)) state_nxt = kfwrl_pkg::ST_WAIT;
      kfwrl_pkg::ST_WAIT:   state_nxt = kfwrl_pkg::ST_FINISH;
      kfwrl_pkg::ST_FINISH: state_nxt = kfwrl_pkg::ST_OUT;
      kfwrl_pkg::ST_OUT:    state_nxt = kfwrl_pkg::ST_IDLE;
      default:              state_nxt = kfwrl_pkg::ST_IDLE;
    endcase
  end

  // finishing write-back and result word
  logic [7:0]  remaining;
  logic        allowed;
  logic        status;
  logic [7:0]  new_count;
  logic [31:0] new_first;
  always_comb begin
    wr_en = 1'b0;
    wr_addr = hit_idx_r;
    wr_data = hit_rec_r;
    allowed = 1'b0;
    remaining = '0;
    status = 1'b0;
    new_count = '0;
    new_first = '0;
    if (state_r == kfwrl_pkg::ST_FINISH && op_r == kfwrl_pkg::OP_RECORD) begin
      if (hit_r) begin
        new_first = expired ? now_r : h_first;
        new_count = expired ? 8'd1 : ((h_count != 8'hFF) ? h_count + 8'd1 : h_count);
        wr_en = 1'b1;
        wr_data = {key_r, new_first, now_r, new_count};
      end else if (free_r) begin
        wr_en = 1'b1;
        wr_addr = free_idx_r;
        wr_data = {key_r, now_r, now_r, 8'd1};
      end else begin
        status = 1'b1;
      end
    end
    if (op_r == kfwrl_pkg::OP_QUERY) begin
      if (!hit_r || expired) begin
        allowed = 1'b1;
        remaining = cfg.attempt_limit;
      end else if (h_count < cfg.attempt_limit) begin
        allowed = 1'b1;
        remaining = cfg.attempt_limit - h_count;
      end
    end
  end

  // scan and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kfwrl_pkg::ST_IDLE;
      valid_r   <= '0;
      now_r     <= '0;
      out_vld_r <= 1'b0;
      rvld_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_vld_r && out_tready) out_vld_r <= 1'b0;
      rvld_r  <= (state_r == kfwrl_pkg::ST_SCAN);
      raddr_r <= cnt_r[AW-1:0];
      if (accept) begin
        op_r      <= in_tdata[2:0];
        key_r     <= in_tdata[3 +: KB];
        cnt_r     <= '0;
        hit_r     <= 1'b0;
        free_r    <= 1'b0;
        removed_r <= '0;
        if (in_tdata[2:0] == kfwrl_pkg::OP_TICK) now_r <= now_r + 32'd1;
      end
      if (state_r == kfwrl_pkg::ST_SCAN) cnt_r <= cnt_r + CW'(1);
      if (rvld_r) begin
        if (valid_r[raddr_r]) begin
          if (op_r == kfwrl_pkg::OP_CLEANUP) begin
            if (stale) begin
              valid_r[raddr_r] <= 1'b0;
              if (removed_r != 7'd127) removed_r <= removed_r + 7'd1;
            end
          end else if (!hit_r && rd_key == key_r) begin
            hit_r     <= 1'b1;
            hit_idx_r <= raddr_r;
            hit_rec_r <= rd_data;
          end
        end else if (!free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= raddr_r;
        end
      end
      if (state_r == kfwrl_pkg::ST_FINISH) begin
        if (op_r == kfwrl_pkg::OP_CLEAR && hit_r) valid_r[hit_idx_r] <= 1'b0;
        if (op_r == kfwrl_pkg::OP_RECORD && !hit_r && free_r)
          valid_r[free_idx_r] <= 1'b1;
      end
      if (state_r == kfwrl_pkg::ST_OUT) out_vld_r <= 1'b1;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state_r == kfwrl_pkg::ST_FINISH)
      out_r <= {7'd0, status, removed_r, remaining, allowed};
    else if (state_r == kfwrl_pkg::ST_IDLE && accept)
      out_r <= '0;
  end

  `KFW_ASSERT_IMPL(a_ready_idle, clk, rst_n, in_tready, state_r == kfwrl_pkg::ST_IDLE)
  `KFW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_vld_r && !out_tready, out_vld_r && $stable(out_r))
  `KFW_ASSERT_IMPL(a_wr_finish, clk, rst_n, wr_en, state_r == kfwrl_pkg::ST_FINISH)
  `KFW_ASSERT_NEXT(a_tick, clk, rst_n, accept && in_tdata[2:0] == kfwrl_pkg::OP_TICK, now_r == $past(now_r) + 32'd1)
endmodule
`default_nettype wire

### hdl/kfwrl_cfg.sv
// ----------------------------------------------------------------------------
// kfwrl_cfg
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none
module kfwrl_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [3:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready,
  output kfwrl_pkg::cfg_t          cfg_o
);
  kfwrl_pkg::cfg_t cfg_r;
  logic            wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_o = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attempt_limit  <= 8'd5;
      cfg_r.window_length  <= 16'd300;
      cfg_r.idle_age_limit <= 16'd3600;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      case (cfg_paddr[3:2])
        kfwrl_pkg::REG_LIMIT:  cfg_r.attempt_limit  <= cfg_pwdata[7:0];
        kfwrl_pkg::REG_WINDOW: cfg_r.window_length  <= cfg_pwdata[15:0];
        kfwrl_pkg::REG_IDLE:   cfg_r.idle_age_limit <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[3:2])
      kfwrl_pkg::REG_LIMIT:  cfg_prdata = {24'd0, cfg_r.attempt_limit};
      kfwrl_pkg::REG_WINDOW: cfg_prdata = {16'd0, cfg_r.window_length};
      kfwrl_pkg::REG_IDLE:   cfg_prdata = {16'd0, cfg_r.idle_age_limit};
      default:               cfg_prdata = '0;
    endcase
  end
endmodule
`default_nettype wire

### hdl/kfwrl_table.sv
// ----------------------------------------------------------------------------
// kfwrl_table
// record memory, one read port and one write port, registered read
// ----------------------------------------------------------------------------
`default_nettype none
module kfwrl_table #(
  parameter int ENTRIES = 64,
  parameter int WIDTH   = 104
) (
  input  wire logic                       clk,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [WIDTH-1:0]                rd_data,
  input  wire logic                       wr_en,
  input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]           wr_data
);
  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire
